// ===== src/icy_pkg.sv =====
package icy_pkg;

	// Byte kinds reported on the result stream
	localparam logic [1:0] KIND_AUDIO  = 2'd0;
	localparam logic [1:0] KIND_LENGTH = 2'd1;
	localparam logic [1:0] KIND_META   = 2'd2;

	// Metadata block sizing: length byte counts units of 16 bytes, at most 512 bytes
	localparam int unsigned META_UNIT      = 16;
	localparam int unsigned META_MAX_BYTES = 512;
	// Largest length byte that still gives a legal block
	localparam logic [7:0]  META_MAX_LEN   = 8'(META_MAX_BYTES / META_UNIT);

	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned REMAIN_W   = 10;
	localparam int unsigned INDEX_W    = 9;

	typedef struct packed {
		logic [INTERVAL_W-1:0] audio_count;
		logic [REMAIN_W-1:0]   meta_remaining;
		logic [INDEX_W-1:0]    meta_position;
	} demux_state_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic [1:0]         byte_kind;
		logic [INDEX_W-1:0] meta_index;
		logic               meta_last;
		logic               length_rejected;
	} demux_result_t;

endpackage

// ===== src/icy_step.sv =====
module icy_step
	import icy_pkg::*;
(
	input  logic [INTERVAL_W-1:0] meta_interval,
	input  demux_state_t          cur,
	input  logic [7:0]            data_byte,
	output demux_state_t          nxt,
	output demux_result_t         res
);

	logic [REMAIN_W-1:0] remain_dec;

	assign remain_dec = cur.meta_remaining - REMAIN_W'(1);

	// Classify one stream byte and advance the counters
	always_comb begin
		nxt                 = cur;
		res.out_byte        = data_byte;
		res.byte_kind       = KIND_AUDIO;
		res.meta_index      = '0;
		res.meta_last       = 1'b0;
		res.length_rejected = 1'b0;

		if (meta_interval == '0) begin
			// pass-through, state holds
			res.byte_kind = KIND_AUDIO;
		end else if (cur.meta_remaining != '0) begin
			res.byte_kind      = KIND_META;
			res.meta_index     = cur.meta_position;
			nxt.meta_remaining = remain_dec;
			if (remain_dec == '0) begin
				res.meta_last     = 1'b1;
				nxt.meta_position = '0;
				nxt.audio_count   = meta_interval;
			end else begin
				nxt.meta_position = cur.meta_position + INDEX_W'(1);
			end
		end else if (cur.audio_count != '0) begin
			res.byte_kind   = KIND_AUDIO;
			nxt.audio_count = cur.audio_count - INTERVAL_W'(1);
		end else if (data_byte == '0) begin
			// empty block: restart the audio interval at once
			res.byte_kind   = KIND_LENGTH;
			nxt.audio_count = meta_interval;
		end else if (data_byte > META_MAX_LEN) begin
			// oversized block: take the byte as first audio byte of a new interval
			res.byte_kind       = KIND_AUDIO;
			res.length_rejected = 1'b1;
			nxt.audio_count     = meta_interval - INTERVAL_W'(1);
		end else begin
			res.byte_kind      = KIND_LENGTH;
			nxt.meta_remaining = {data_byte[REMAIN_W-5:0], 4'b0000};
			nxt.meta_position  = '0;
		end
	end

endmodule

// ===== src/icy_metadata_demux.sv =====
// ICY metadata demultiplexer. Takes a received ICY stream one byte per transfer and
// returns one tagged byte per input byte: audio, metadata length byte, or metadata
// byte with its index in the block (tlast marks the final metadata byte). A length
// byte above 32 (block over 512 bytes) is returned as audio with the rejected flag.
// It takes one byte per clock cycle unless the result stream stalls; each result is
// registered, and each byte makes a single counter update to the demux state. Writing
// meta_interval (0 disables demultiplexing) restarts the audio count and drops any
// block in progress; write it only while the stream is idle.
module icy_metadata_demux
	import icy_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration: meta_interval
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [INTERVAL_W-1:0] cfg_data,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // [7:0] out_byte, [16:8] meta_index, zeros
	output logic [2:0]            m_axis_tuser,  // [1:0] byte_kind, [2] length_rejected
	output logic                  m_axis_tlast   // meta_last
);

	logic [INTERVAL_W-1:0] meta_interval_q;
	demux_state_t          state_q;
	demux_state_t          state_nxt;
	demux_result_t         step_res;
	demux_result_t         res_q;
	logic                  res_valid_q;
	logic                  in_xfer;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !res_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	icy_step u_step (
		.meta_interval (meta_interval_q),
		.cur           (state_q),
		.data_byte     (s_axis_tdata),
		.nxt           (state_nxt),
		.res           (step_res)
	);

	// Load the interval and restart counting on a config write, else advance per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_interval_q <= '0;
			state_q         <= '0;
		end else if (cfg_valid && cfg_ready) begin
			meta_interval_q        <= cfg_data;
			state_q.audio_count    <= cfg_data;
			state_q.meta_remaining <= '0;
			state_q.meta_position  <= '0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result until the downstream transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_xfer) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= step_res;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {7'b0, res_q.meta_index, res_q.out_byte};
	assign m_axis_tuser  = {res_q.length_rejected, res_q.byte_kind};
	assign m_axis_tlast  = res_q.meta_last;

	// A block never exceeds 512 bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.meta_remaining <= REMAIN_W'(META_MAX_BYTES))
		else $error("metadata remaining count above block maximum");

	// Index plus bytes left never exceeds the 512-byte block maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.meta_remaining != '0 |->
		({1'b0, state_q.meta_position} + state_q.meta_remaining) <= REMAIN_W'(META_MAX_BYTES))
		else $error("metadata position and remaining count disagree");

	// The last marker only comes with a metadata byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == KIND_META)
		else $error("last marker on a non-metadata byte");

	// A rejected length byte is reported as audio
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == KIND_AUDIO)
		else $error("rejected length byte not reported as audio");

	// With demultiplexing off, the state stays put on every byte
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !cfg_valid && meta_interval_q == '0 |=> $stable(state_q))
		else $error("state changed while demultiplexing is disabled");

endmodule
